// ----- src/fsgs_pkg.sv -----
package fsgs_pkg;

    // Default grid size and the address width that follows from it
    localparam int GRID_COLUMNS_DEF = 256;
    localparam int GRID_ROWS_DEF    = 128;
    localparam int GRID_ADDR_W_DEF  = $clog2(GRID_COLUMNS_DEF) + $clog2(GRID_ROWS_DEF);

    // Field and register widths
    localparam int CELL_X_W   = 8;
    localparam int CELL_Y_W   = 7;
    localparam int CFG_COLS_W = 9;
    localparam int CFG_ROWS_W = 8;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_COLS_W-1:0] CFG_COLS_RESET = 9'd192;
    localparam logic [CFG_ROWS_W-1:0] CFG_ROWS_RESET = 8'd128;

    typedef enum logic [0:0] {
        CFG_COLUMNS = 1'b0,
        CFG_ROWS    = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        KIND_TICK = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        MAT_EMPTY = 2'd0,
        MAT_SAND  = 2'd1,
        MAT_WATER = 2'd2,
        MAT_SOLID = 2'd3
    } mat_t;

    // One grid entry: material plus the per-sweep updated flag
    typedef struct packed {
        logic flag;
        mat_t mat;
    } cell_t;

    // Neighbor offsets relative to the current cell
    typedef enum logic [2:0] {
        OFS_C  = 3'd0,
        OFS_D  = 3'd1,
        OFS_DL = 3'd2,
        OFS_DR = 3'd3,
        OFS_L  = 3'd4,
        OFS_R  = 3'd5
    } ofs_t;

    // Write data and address source
    typedef enum logic [2:0] {
        WS_CLEAR  = 3'd0,
        WS_VACATE = 3'd1,
        WS_UNFLAG = 3'd2,
        WS_SPAWN  = 3'd3,
        WS_MOVE   = 3'd4
    } wsrc_t;

    // Datapath register operations
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_LATCH_CUR  = 3'd1,
        OP_SWEEP_INIT = 3'd2,
        OP_ADVANCE    = 3'd3,
        OP_CLR_INC    = 3'd4,
        OP_LOAD_READ  = 3'd5,
        OP_LOAD_TICK  = 3'd6
    } dp_op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER      = 4'd0,
        C_NO_ITEM    = 4'd1,
        C_KIND_READ  = 4'd2,
        C_FLAGGED    = 4'd3,
        C_NOT_MOVER  = 4'd4,
        C_OK_D       = 4'd5,
        C_OK_DL      = 4'd6,
        C_OK_DR      = 4'd7,
        C_OK_L       = 4'd8,
        C_NOT_OK_R   = 4'd9,
        C_SAND       = 4'd10,
        C_LAST       = 4'd11,
        C_CLR_LAST   = 4'd12,
        C_OUT_BUSY   = 4'd13,
        C_SPAWN_OK   = 4'd14,
        C_AREA_EMPTY = 4'd15
    } cond_t;

    // Microprogram step addresses
    typedef enum logic [4:0] {
        ST_CLEAR    = 5'd0,
        ST_IDLE     = 5'd1,
        ST_DISPATCH = 5'd2,
        ST_RD_ISSUE = 5'd3,
        ST_RD_DONE  = 5'd4,
        ST_SP_READ  = 5'd5,
        ST_SP_TEST  = 5'd6,
        ST_SP_WRITE = 5'd7,
        ST_SW_INIT  = 5'd8,
        ST_VISIT    = 5'd9,
        ST_EVAL     = 5'd10,
        ST_KIND     = 5'd11,
        ST_TRY_D    = 5'd12,
        ST_TRY_DL   = 5'd13,
        ST_TRY_DR   = 5'd14,
        ST_IS_SAND  = 5'd15,
        ST_TRY_L    = 5'd16,
        ST_TRY_R    = 5'd17,
        ST_MOVE_D   = 5'd18,
        ST_MOVE_DL  = 5'd19,
        ST_MOVE_DR  = 5'd20,
        ST_MOVE_L   = 5'd21,
        ST_MOVE_R   = 5'd22,
        ST_VACATE   = 5'd23,
        ST_UNFLAG   = 5'd24,
        ST_ADVANCE  = 5'd25,
        ST_FINISH   = 5'd26
    } step_t;

    // Control word of one microprogram step
    typedef struct packed {
        logic   accept;
        logic   rd_en;
        ofs_t   rd_ofs;
        logic   wr_en;
        wsrc_t  wr_src;
        ofs_t   wr_ofs;
        dp_op_t op;
        cond_t  cond;
        step_t  jmp;
        step_t  seq;
    } ctl_t;

    // Status flags from the datapath, one per jump condition other than C_NEVER
    typedef struct packed {
        logic no_item;
        logic kind_read;
        logic flagged;
        logic not_mover;
        logic ok_d;
        logic ok_dl;
        logic ok_dr;
        logic ok_l;
        logic ok_r;
        logic sand;
        logic last;
        logic clr_last;
        logic out_busy;
        logic spawn_ok;
        logic area_empty;
    } stat_t;

    function automatic ctl_t mk(
        logic   acc,
        logic   rde,
        ofs_t   rdo,
        logic   wre,
        wsrc_t  ws,
        ofs_t   wo,
        dp_op_t op,
        cond_t  c,
        step_t  j,
        step_t  n
    );
        ctl_t w;
        w.accept = acc;
        w.rd_en  = rde;
        w.rd_ofs = rdo;
        w.wr_en  = wre;
        w.wr_src = ws;
        w.wr_ofs = wo;
        w.op     = op;
        w.cond   = c;
        w.jmp    = j;
        w.seq    = n;
        return w;
    endfunction

    // Microprogram ROM
    function automatic ctl_t ucode(step_t s);
        ctl_t w;
        unique case (s)
            ST_CLEAR:    w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_CLEAR,  OFS_C,  OP_CLR_INC,
                                C_CLR_LAST, ST_IDLE, ST_CLEAR);
            ST_IDLE:     w = mk(1'b1, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_NO_ITEM, ST_IDLE, ST_DISPATCH);
            ST_DISPATCH: w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_KIND_READ, ST_RD_ISSUE, ST_SP_READ);
            ST_RD_ISSUE: w = mk(1'b0, 1'b1, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_NEVER, ST_RD_DONE, ST_RD_DONE);
            ST_RD_DONE:  w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_LOAD_READ,
                                C_OUT_BUSY, ST_RD_DONE, ST_IDLE);
            ST_SP_READ:  w = mk(1'b0, 1'b1, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_NEVER, ST_SP_TEST, ST_SP_TEST);
            ST_SP_TEST:  w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_SPAWN_OK, ST_SP_WRITE, ST_SW_INIT);
            ST_SP_WRITE: w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_SPAWN,  OFS_C,  OP_NONE,
                                C_NEVER, ST_SW_INIT, ST_SW_INIT);
            ST_SW_INIT:  w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_SWEEP_INIT,
                                C_AREA_EMPTY, ST_FINISH, ST_VISIT);
            ST_VISIT:    w = mk(1'b0, 1'b1, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_NEVER, ST_EVAL, ST_EVAL);
            ST_EVAL:     w = mk(1'b0, 1'b1, OFS_D,  1'b0, WS_VACATE, OFS_C,  OP_LATCH_CUR,
                                C_FLAGGED, ST_UNFLAG, ST_KIND);
            ST_KIND:     w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_NOT_MOVER, ST_ADVANCE, ST_TRY_D);
            ST_TRY_D:    w = mk(1'b0, 1'b1, OFS_DL, 1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_OK_D, ST_MOVE_D, ST_TRY_DL);
            ST_TRY_DL:   w = mk(1'b0, 1'b1, OFS_DR, 1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_OK_DL, ST_MOVE_DL, ST_TRY_DR);
            ST_TRY_DR:   w = mk(1'b0, 1'b1, OFS_L,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_OK_DR, ST_MOVE_DR, ST_IS_SAND);
            ST_IS_SAND:  w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_SAND, ST_ADVANCE, ST_TRY_L);
            ST_TRY_L:    w = mk(1'b0, 1'b1, OFS_R,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_OK_L, ST_MOVE_L, ST_TRY_R);
            ST_TRY_R:    w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_NOT_OK_R, ST_ADVANCE, ST_MOVE_R);
            ST_MOVE_D:   w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_MOVE,   OFS_D,  OP_NONE,
                                C_NEVER, ST_VACATE, ST_VACATE);
            ST_MOVE_DL:  w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_MOVE,   OFS_DL, OP_NONE,
                                C_NEVER, ST_VACATE, ST_VACATE);
            ST_MOVE_DR:  w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_MOVE,   OFS_DR, OP_NONE,
                                C_NEVER, ST_VACATE, ST_VACATE);
            ST_MOVE_L:   w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_MOVE,   OFS_L,  OP_NONE,
                                C_NEVER, ST_VACATE, ST_VACATE);
            ST_MOVE_R:   w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_MOVE,   OFS_R,  OP_NONE,
                                C_NEVER, ST_VACATE, ST_VACATE);
            ST_VACATE:   w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_VACATE, OFS_C,  OP_ADVANCE,
                                C_LAST, ST_FINISH, ST_VISIT);
            ST_UNFLAG:   w = mk(1'b0, 1'b0, OFS_C,  1'b1, WS_UNFLAG, OFS_C,  OP_ADVANCE,
                                C_LAST, ST_FINISH, ST_VISIT);
            ST_ADVANCE:  w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_ADVANCE,
                                C_LAST, ST_FINISH, ST_VISIT);
            ST_FINISH:   w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_LOAD_TICK,
                                C_OUT_BUSY, ST_FINISH, ST_IDLE);
            default:     w = mk(1'b0, 1'b0, OFS_C,  1'b0, WS_VACATE, OFS_C,  OP_NONE,
                                C_NEVER, ST_IDLE, ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ----- src/fsgs_grid_mem.sv -----
module fsgs_grid_mem #(
    parameter int ADDR_W = fsgs_pkg::GRID_ADDR_W_DEF
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output fsgs_pkg::cell_t     rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  fsgs_pkg::cell_t     wr_data
);
    import fsgs_pkg::*;

    cell_t grid_array [0:(1 << ADDR_W) - 1];
    cell_t rd_data_reg;

    // Write one entry and read one entry per cycle; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= grid_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/fsgs_sequencer.sv -----
module fsgs_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  fsgs_pkg::stat_t status,
    output fsgs_pkg::ctl_t  ctl
);
    import fsgs_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    logic  cond_true;

    // Hold the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_CLEAR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // Fetch the control word, pick the condition and branch
    always_comb
    begin
        ctl = ucode(upc_reg);
        unique case (ctl.cond)
            C_NEVER:      cond_true = 1'b0;
            C_NO_ITEM:    cond_true = status.no_item;
            C_KIND_READ:  cond_true = status.kind_read;
            C_FLAGGED:    cond_true = status.flagged;
            C_NOT_MOVER:  cond_true = status.not_mover;
            C_OK_D:       cond_true = status.ok_d;
            C_OK_DL:      cond_true = status.ok_dl;
            C_OK_DR:      cond_true = status.ok_dr;
            C_OK_L:       cond_true = status.ok_l;
            C_NOT_OK_R:   cond_true = !status.ok_r;
            C_SAND:       cond_true = status.sand;
            C_LAST:       cond_true = status.last;
            C_CLR_LAST:   cond_true = status.clr_last;
            C_OUT_BUSY:   cond_true = status.out_busy;
            C_SPAWN_OK:   cond_true = status.spawn_ok;
            C_AREA_EMPTY: cond_true = status.area_empty;
        endcase
        upc_next = cond_true ? ctl.jmp : ctl.seq;
    end

endmodule

// ----- src/fsgs_datapath.sv -----
module fsgs_datapath #(
    parameter int GRID_COLUMNS = fsgs_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = fsgs_pkg::GRID_ROWS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fsgs_pkg::ctl_t                          ctl,
    output fsgs_pkg::stat_t                         status,
    // input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    kind,
    input  logic                                    spawn_enable,
    input  logic [1:0]                              spawn_material,
    input  logic [fsgs_pkg::CELL_X_W-1:0]           cell_x,
    input  logic [fsgs_pkg::CELL_Y_W-1:0]           cell_y,
    // output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [1:0]                              cell_material,
    output logic                                    tick_done,
    // configuration
    input  logic                                    cfg_write,
    input  fsgs_pkg::cfg_idx_t                      cfg_index,
    input  logic [fsgs_pkg::CFG_DATA_W-1:0]         cfg_data,
    // grid memory
    output logic                                    mem_rd_en,
    output logic [$clog2(GRID_COLUMNS)+$clog2(GRID_ROWS)-1:0] mem_rd_addr,
    input  fsgs_pkg::cell_t                         mem_rd_data,
    output logic                                    mem_wr_en,
    output logic [$clog2(GRID_COLUMNS)+$clog2(GRID_ROWS)-1:0] mem_wr_addr,
    output fsgs_pkg::cell_t                         mem_wr_data
);
    import fsgs_pkg::*;

    localparam int XW  = $clog2(GRID_COLUMNS);
    localparam int YW  = $clog2(GRID_ROWS);
    localparam int AW  = XW + YW;
    localparam int XCW = (XW + 1 > CFG_COLS_W) ? XW + 1 : CFG_COLS_W;
    localparam int YCW = (YW + 1 > CFG_ROWS_W) ? YW + 1 : CFG_ROWS_W;

    // control registers
    logic [CFG_COLS_W-1:0] cols_reg, cols_next;
    logic [CFG_ROWS_W-1:0] rows_reg, rows_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;

    // payload registers
    kind_t                 kind_reg, kind_next;
    logic                  spawn_en_reg, spawn_en_next;
    mat_t                  spawn_mat_reg, spawn_mat_next;
    logic [XCW-1:0]        x_reg, x_next;
    logic [YCW-1:0]        y_reg, y_next;
    cell_t                 cur_reg, cur_next;
    mat_t                  mat_out_reg, mat_out_next;
    logic                  done_out_reg, done_out_next;

    logic [XCW-1:0]        w_act, x_plus, x_minus;
    logic [YCW-1:0]        h_act, y_plus;
    logic                  in_xfer, out_free, in_area, rd_empty;
    logic                  y_inc_ok, x_dec_ok, x_inc_ok;

    // Address of a neighbor of the current cell
    function automatic logic [AW-1:0] cell_addr(ofs_t o);
        logic [XCW-1:0] ax;
        logic [YCW-1:0] ay;
        ax = x_reg;
        ay = y_reg;
        unique case (o)
            OFS_C:
            begin
                ax = x_reg;
                ay = y_reg;
            end
            OFS_D:
            begin
                ax = x_reg;
                ay = y_plus;
            end
            OFS_DL:
            begin
                ax = x_minus;
                ay = y_plus;
            end
            OFS_DR:
            begin
                ax = x_plus;
                ay = y_plus;
            end
            OFS_L:
            begin
                ax = x_minus;
                ay = y_reg;
            end
            OFS_R:
            begin
                ax = x_plus;
                ay = y_reg;
            end
            default:
            begin
                ax = x_reg;
                ay = y_reg;
            end
        endcase
        return {ay[YW-1:0], ax[XW-1:0]};
    endfunction

    // Active area, saturated to the grid size
    always_comb
    begin
        w_act = (XCW'(cols_reg) < XCW'(GRID_COLUMNS)) ? XCW'(cols_reg) : XCW'(GRID_COLUMNS);
        h_act = (YCW'(rows_reg) < YCW'(GRID_ROWS)) ? YCW'(rows_reg) : YCW'(GRID_ROWS);
    end

    assign x_plus   = x_reg + XCW'(1);
    assign x_minus  = x_reg - XCW'(1);
    assign y_plus   = y_reg + YCW'(1);
    assign y_inc_ok = y_plus < h_act;
    assign x_dec_ok = x_reg != '0;
    assign x_inc_ok = x_plus < w_act;
    assign in_area  = (x_reg < w_act) && (y_reg < h_act);
    assign rd_empty = mem_rd_data.mat == MAT_EMPTY;
    assign in_xfer  = ctl.accept && in_valid;
    assign out_free = !out_valid_reg || !out_stall;

    // Report status flags to the sequencer
    always_comb
    begin
        status.no_item    = !in_valid;
        status.kind_read  = kind_reg == KIND_READ;
        status.flagged    = mem_rd_data.flag;
        status.not_mover  = (cur_reg.mat != MAT_SAND) && (cur_reg.mat != MAT_WATER);
        status.ok_d       = y_inc_ok && rd_empty;
        status.ok_dl      = y_inc_ok && x_dec_ok && rd_empty;
        status.ok_dr      = y_inc_ok && x_inc_ok && rd_empty;
        status.ok_l       = x_dec_ok && rd_empty;
        status.ok_r       = x_inc_ok && rd_empty;
        status.sand       = cur_reg.mat == MAT_SAND;
        status.last       = (x_plus == w_act) && (y_plus == h_act);
        status.clr_last   = &clr_reg;
        status.out_busy   = !out_free;
        status.spawn_ok   = spawn_en_reg && in_area && rd_empty;
        status.area_empty = (w_act == '0) || (h_act == '0);
    end

    // Drive the memory ports
    always_comb
    begin
        mem_rd_en   = ctl.rd_en;
        mem_rd_addr = cell_addr(ctl.rd_ofs);
        mem_wr_en   = ctl.wr_en;
        mem_wr_addr = cell_addr(OFS_C);
        mem_wr_data = '0;
        case (ctl.wr_src)
            WS_CLEAR:
            begin
                mem_wr_addr = clr_reg;
            end
            WS_UNFLAG:
            begin
                mem_wr_data.mat = cur_reg.mat;
            end
            WS_SPAWN:
            begin
                mem_wr_data.mat = spawn_mat_reg;
            end
            WS_MOVE:
            begin
                // a particle landing in the current or next column keeps its flag;
                // the previous column is not visited again in this sweep
                mem_wr_addr      = cell_addr(ctl.wr_ofs);
                mem_wr_data.mat  = cur_reg.mat;
                mem_wr_data.flag = (ctl.wr_ofs == OFS_D) || (ctl.wr_ofs == OFS_DR)
                                   || (ctl.wr_ofs == OFS_R);
            end
            default:
            begin
                mem_wr_data = '0;
            end
        endcase
    end

    // Next values of the datapath registers
    always_comb
    begin
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        spawn_en_next  = spawn_en_reg;
        spawn_mat_next = spawn_mat_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cur_next       = cur_reg;
        mat_out_next   = mat_out_reg;
        done_out_next  = done_out_reg;

        // take a configuration write
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: cols_next = cfg_data[CFG_COLS_W-1:0];
                CFG_ROWS:    rows_next = cfg_data[CFG_ROWS_W-1:0];
            endcase
        end

        // latch an accepted item
        if (in_xfer)
        begin
            kind_next      = kind_t'(kind);
            spawn_en_next  = spawn_enable;
            spawn_mat_next = mat_t'(spawn_material);
            x_next         = XCW'(cell_x);
            y_next         = YCW'(cell_y);
        end

        // drop the result once transferred
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctl.op)
            OP_NONE:
            begin
            end
            OP_LATCH_CUR:
            begin
                cur_next = mem_rd_data;
            end
            OP_SWEEP_INIT:
            begin
                x_next = '0;
                y_next = '0;
            end
            OP_ADVANCE:
            begin
                if (y_plus == h_act)
                begin
                    y_next = '0;
                    x_next = x_plus;
                end
                else
                begin
                    y_next = y_plus;
                end
            end
            OP_CLR_INC:
            begin
                clr_next = clr_reg + AW'(1);
            end
            OP_LOAD_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mat_out_next   = in_area ? mem_rd_data.mat : MAT_EMPTY;
                    done_out_next  = 1'b0;
                end
            end
            OP_LOAD_TICK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mat_out_next   = MAT_EMPTY;
                    done_out_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg      <= CFG_COLS_RESET;
            rows_reg      <= CFG_ROWS_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        spawn_en_reg  <= spawn_en_next;
        spawn_mat_reg <= spawn_mat_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        cur_reg       <= cur_next;
        mat_out_reg   <= mat_out_next;
        done_out_reg  <= done_out_next;
    end

    assign in_stall      = !ctl.accept;
    assign out_valid     = out_valid_reg;
    assign cell_material = mat_out_reg;
    assign tick_done     = done_out_reg;

endmodule

// ----- src/falling_sand_grid_step_unit.sv -----
// Falling-sand grid engine.
// Input channel (in_valid / in_stall) takes one item per transfer: kind 0 is a tick
// that may first drop a particle at (cell_x, cell_y), then sweeps the active area
// column by column, top to bottom; kind 1 reads the material of one cell.
// Every item gives one result on the output channel (out_valid / out_stall):
// a tick returns tick_done = 1, a read returns the cell's material.
// The engine works on one item at a time and holds in_stall high until it is
// back in its idle step. A read goes through the dispatch, read-issue and
// read-done steps; read-done waits while the output register is busy.
// A tick goes through the dispatch, spawn read, spawn test, optional spawn
// write and sweep init steps, then visits each active cell: an empty or solid cell
// leaves after the kind check, water that ends up moving right tries every move.
// After reset the engine clears all 2^(clog2(GRID_COLUMNS) + clog2(GRID_ROWS))
// grid memory entries (32768 at the default size), one entry per cycle, with
// in_stall high; configuration writes are taken at any time.
// A stalled result stays in the output register; a finished item waits for the
// result register to free up before it loads its own result.
module falling_sand_grid_step_unit #(
    parameter int GRID_COLUMNS = fsgs_pkg::GRID_COLUMNS_DEF,
    parameter int GRID_ROWS    = fsgs_pkg::GRID_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic                              spawn_enable,
    input  logic [1:0]                        spawn_material,
    input  logic [fsgs_pkg::CELL_X_W-1:0]     cell_x,
    input  logic [fsgs_pkg::CELL_Y_W-1:0]     cell_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        cell_material,
    output logic                              tick_done,
    input  logic                              cfg_write,
    input  fsgs_pkg::cfg_idx_t                cfg_index,
    input  logic [fsgs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fsgs_pkg::*;

    localparam int AW = $clog2(GRID_COLUMNS) + $clog2(GRID_ROWS);

    ctl_t          ctl;
    stat_t         status;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    cell_t         mem_rd_data;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    cell_t         mem_wr_data;

    fsgs_sequencer u_sequencer (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    fsgs_datapath #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .spawn_enable   (spawn_enable),
        .spawn_material (spawn_material),
        .cell_x         (cell_x),
        .cell_y         (cell_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_material  (cell_material),
        .tick_done      (tick_done),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data)
    );

    fsgs_grid_mem #(
        .ADDR_W (AW)
    ) u_grid_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // One item at a time: the engine is busy right after a transfer
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input accepted in the cycle after a transfer");

    // The idle step never writes the grid
    a_no_write_when_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.accept |-> !mem_wr_en
    ) else $error("grid written while waiting for an item");

    // The clearing pass keeps the input channel closed
    a_clear_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (mem_wr_en && (ctl.wr_src == WS_CLEAR)) |-> in_stall
    ) else $error("input open during the clearing pass");

    // A tick result carries no material
    a_tick_result_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && tick_done) |-> (cell_material == MAT_EMPTY)
    ) else $error("tick result with nonzero material");

endmodule
